// File: rtl/core/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants of the ordered value list: capacity, widths,
// command and status codes, and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DW = 32;
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FOUND    = 3'd4,
    ST_ENTRY    = 3'd5,
    ST_EMPTY    = 3'd6
  } status_e;

  // Source of the result data word
  typedef enum logic [1:0] {
    SEL_VALUE = 2'd0,
    SEL_RDATA = 2'd1,
    SEL_ZERO  = 2'd2
  } sel_e;

  typedef struct packed {
    logic    take;       // latch operand of the accepted transfer
    logic    ins_wr;     // append operand at the tail
    logic    shift_wr;   // write read-back word one place lower
    logic    ptr_clr;
    logic    ptr_next;   // restart reading just past the read-back entry
    logic    rd_en;
    logic    rhold;      // keep the read-back word for a later cycle
    logic    cnt_dec;
    logic    out_load;
    status_e out_status;
    sel_e    out_sel;
    logic    out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_end;     // read pointer reached the entry count
    logic rvalid;     // read-back word pending
    logic match;      // read-back word equals operand
    logic ridx_last;  // read-back word is the tail entry
    logic out_free;   // output register can load this cycle
  } dp_stat_t;

endpackage

// File: rtl/core/olist_dp.sv
// ----------------------------------------------------------------------------
// olist_dp
// Datapath: entry memory, entry count, read pointer with registered read
// port, operand register and the output result register.
// ----------------------------------------------------------------------------
module olist_dp import olist_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic        [DW-1:0] in_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic        [2:0]    out_status_o,
  output logic        [DW-1:0] out_data_o,
  output logic                 out_last_o
);

  logic [DW-1:0] entries_q [CAPACITY];
  logic [DW-1:0] rdata_q;
  logic [AW-1:0] ridx_q;
  logic          rvalid_q, rvalid_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [DW-1:0] value_q;
  logic          out_valid_q, out_valid_d;
  status_e       out_status_q;
  logic [DW-1:0] out_data_q, out_data_d;
  logic          out_last_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Memory write port: tail append or one-place shift during removal
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[AW-1:0];
    wr_data = in_data_i;
    if (cmd_i.ins_wr) begin
      wr_en = 1'b1;
    end else if (cmd_i.shift_wr && rvalid_q) begin
      wr_en   = 1'b1;
      wr_addr = ridx_q - AW'(1);
      wr_data = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entries_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= entries_q[ptr_q[AW-1:0]];
      ridx_q  <= ptr_q[AW-1:0];
    end
    if (cmd_i.take) begin
      value_q <= in_data_i;
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_data_q   <= out_data_d;
      out_last_q   <= cmd_i.out_last;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_next) begin
      ptr_d = CW'(ridx_q) + CW'(1);
    end else if (cmd_i.rd_en) begin
      ptr_d = ptr_q + CW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins_wr) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  assign rvalid_d = cmd_i.rd_en || cmd_i.rhold;

  always_comb begin
    case (cmd_i.out_sel)
      SEL_VALUE: out_data_d = value_q;
      SEL_RDATA: out_data_d = rdata_q;
      default:   out_data_d = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.full      = (count_q == CW'(CAPACITY));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.at_end    = (ptr_q == count_q);
  assign stat_o.rvalid    = rvalid_q;
  assign stat_o.match     = rvalid_q && (rdata_q == value_q);
  assign stat_o.ridx_last = (CW'(ridx_q) + CW'(1) == count_q);
  assign stat_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;
  assign out_last_o   = out_last_q;

endmodule

// File: rtl/core/olist_ctrl.sv
// ----------------------------------------------------------------------------
// olist_ctrl
// Controller: accepts one command at a time and sequences the scan, the
// compaction after a removal, the list walk and the single-result replies.
// ----------------------------------------------------------------------------
module olist_ctrl import olist_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic       in_ready_o,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST,
    S_RESP
  } state_e;

  state_e  state_q, state_d;
  status_e resp_q, resp_d;
  sel_e    sel_q, sel_d;
  logic    remove_q, remove_d;
  cmd_e    in_cmd;

  assign in_cmd     = cmd_e'(in_cmd_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    resp_d   = resp_q;
    sel_d    = sel_q;
    remove_d = remove_q;
    cmd_o    = '0;
    cmd_o.out_status = resp_q;
    cmd_o.out_sel    = sel_q;
    cmd_o.out_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          sel_d      = SEL_VALUE;
          unique case (in_cmd)
            CMD_INSERT: begin
              cmd_o.ins_wr = !stat_i.full;
              resp_d       = stat_i.full ? ST_FULL : ST_INSERTED;
              state_d      = S_RESP;
            end
            CMD_REMOVE, CMD_SEARCH: begin
              cmd_o.ptr_clr = 1'b1;
              remove_d      = (in_cmd == CMD_REMOVE);
              state_d       = S_SCAN;
            end
            CMD_LIST: begin
              if (stat_i.empty) begin
                resp_d  = ST_EMPTY;
                sel_d   = SEL_ZERO;
                state_d = S_RESP;
              end else begin
                cmd_o.ptr_clr = 1'b1;
                state_d       = S_LIST;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // Stream reads; compare each word in the cycle after it is read
      S_SCAN: begin
        if (stat_i.match) begin
          if (remove_q) begin
            cmd_o.ptr_next = 1'b1;
            state_d        = S_SHIFT;
          end else begin
            resp_d  = ST_FOUND;
            state_d = S_RESP;
          end
        end else if (stat_i.at_end && !stat_i.rvalid) begin
          resp_d  = ST_MISSING;
          state_d = S_RESP;
        end else begin
          cmd_o.rd_en = !stat_i.at_end;
        end
      end

      // Move every entry past the match one place toward the head
      S_SHIFT: begin
        cmd_o.shift_wr = 1'b1;
        if (stat_i.at_end && !stat_i.rvalid) begin
          cmd_o.cnt_dec = 1'b1;
          resp_d        = ST_REMOVED;
          state_d       = S_RESP;
        end else begin
          cmd_o.rd_en = !stat_i.at_end;
        end
      end

      S_LIST: begin
        cmd_o.out_status = ST_ENTRY;
        cmd_o.out_sel    = SEL_RDATA;
        cmd_o.out_last   = stat_i.ridx_last;
        cmd_o.out_load   = stat_i.rvalid && stat_i.out_free;
        cmd_o.rhold      = stat_i.rvalid && !stat_i.out_free;
        cmd_o.rd_en      = !stat_i.at_end && (!stat_i.rvalid || stat_i.out_free);
        if (cmd_o.out_load && stat_i.ridx_last) begin
          state_d = S_IDLE;
        end
      end

      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      resp_q   <= ST_INSERTED;
      sel_q    <= SEL_VALUE;
      remove_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      resp_q   <= resp_d;
      sel_q    <= sel_d;
      remove_q <= remove_d;
    end
  end

endmodule

// File: rtl/core/ordered_value_list.sv
// ----------------------------------------------------------------------------
// ordered_value_list
// Ordered list of signed 32-bit values with insert, remove, search and list.
// ----------------------------------------------------------------------------
// The block holds up to CAPACITY (64) values in a single-port-write,
// registered-read memory and handles one command at a time; s_axis_tready_o
// is high only between commands, while a finished result may still wait in
// the output register. Search and remove read entries one per cycle through
// the memory's read port, and after a removal every later entry is rewritten
// one place down through the write port. List delivers one entry per cycle,
// slowed only by m_axis_tready_i. An insert into a full list leaves the list
// unchanged and reports status full. No clearing pass is needed after reset.
module ordered_value_list import olist_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic signed [31:0]   s_axis_tdata_i,   // [31:0] value
  input  logic        [1:0]    s_axis_tuser_i,   // [1:0] command
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic signed [31:0]   m_axis_tdata_o,   // [31:0] entry_value
  output logic        [2:0]    m_axis_tuser_o,   // [2:0] status
  output logic                 m_axis_tlast_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  olist_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_cmd_i   (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  olist_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .in_data_i    (s_axis_tdata_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_status_o (m_axis_tuser_o),
    .out_data_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

  // No read may be in flight when a new command is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !dp_stat.rvalid)
    else $error("read pending while idle");

  // Never append to a full list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_stat.full |-> !dp_cmd.ins_wr)
    else $error("append into full list");

  // Every result other than a list entry closes its command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_ENTRY) |-> m_axis_tlast_o)
    else $error("single result without tlast");

endmodule

// File: sim/ordered_value_list_test.sv
// ----------------------------------------------------------------------------
// ordered_value_list_test
// Self-checking bench for the ordered value list. A queue of commands feeds a
// stream driver; a shadow copy of the list predicts every result, and a
// monitor compares each output transfer field by field against the oldest
// prediction. Directed corner cases come first, then a fill to capacity with
// a long receiver stall, then random phases with bursty idling on both sides.
// ----------------------------------------------------------------------------
module ordered_value_list_test;
  import olist_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAIL_ITEMS    = 40;
  localparam int RANDOM_ITEMS  = 400;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT   = 5000;

  typedef struct {
    cmd_e               cmd;
    logic signed [31:0] value;
    bit                 wait_drain;  // hold until every result has arrived
  } command_t;

  typedef struct {
    status_e            status;
    logic signed [31:0] value;
    logic               last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic signed [31:0] in_value = '0;
  cmd_e               in_cmd = CMD_INSERT;
  logic               out_ready = 1'b0;

  logic               s_axis_tready_o;
  logic               m_axis_tvalid_o;
  logic signed [31:0] m_axis_tdata_o;
  logic [2:0]         m_axis_tuser_o;
  logic               m_axis_tlast_o;

  command_t           command_queue[$];
  result_t            pending_results[$];
  logic signed [31:0] held_values[$];

  int accepted_cnt = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int stall_at = 0;
  int tx_gap = 0;
  int rx_hold = 0;
  bit stall_done = 1'b0;
  bit idle_tx = 1'b1;
  bit idle_rx = 1'b1;

  ordered_value_list dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_value),
    .s_axis_tuser_i  (in_cmd),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void queue_command(cmd_e cmd, logic signed [31:0] value,
                                        bit wait_drain);
    command_queue.push_back('{cmd, value, wait_drain});
  endfunction

  function automatic void expect_result(status_e status, logic signed [31:0] value,
                                        logic last);
    pending_results.push_back('{status, value, last});
  endfunction

  // Mix of fully random words, extremes and a narrow band that makes duplicates
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] corner[4];
    corner[0] = 32'sh8000_0000;
    corner[1] = 32'sh7fff_ffff;
    corner[2] = '0;
    corner[3] = -32'sd1;
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return corner[$urandom_range(0, 3)];
      default: return $signed($urandom_range(0, 15)) - 32'sd8;
    endcase
  endfunction

  // Update the shadow list and queue the results one command should produce
  function automatic void apply_command(cmd_e cmd, logic signed [31:0] value);
    int pos;
    pos = -1;
    for (int i = 0; i < held_values.size(); i++) begin
      if (pos < 0 && held_values[i] == value) pos = i;
    end
    case (cmd)
      CMD_INSERT: begin
        if (held_values.size() >= CAPACITY) begin
          expect_result(ST_FULL, value, 1'b1);
        end else begin
          held_values.push_back(value);
          expect_result(ST_INSERTED, value, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (pos < 0) begin
          expect_result(ST_MISSING, value, 1'b1);
        end else begin
          held_values.delete(pos);
          expect_result(ST_REMOVED, value, 1'b1);
        end
      end
      CMD_SEARCH: begin
        if (pos < 0) expect_result(ST_MISSING, value, 1'b1);
        else expect_result(ST_FOUND, held_values[pos], 1'b1);
      end
      default: begin
        if (held_values.size() == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < held_values.size(); i++)
            expect_result(ST_ENTRY, held_values[i], i == held_values.size() - 1);
        end
      end
    endcase
  endfunction

  always @(posedge clk_i) begin : drive
    logic     nxt_valid;
    command_t cur;
    nxt_valid = in_valid;
    if (rst_ni) begin
      if (in_valid && s_axis_tready_o) begin
        apply_command(in_cmd, in_value);
        accepted_cnt++;
        nxt_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) idle_tx = !idle_tx;
        if (idle_tx && command_queue.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
          tx_gap = $urandom_range(1, 18);
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (command_queue.size() != 0 &&
                     !(command_queue[0].wait_drain && pending_results.size() != 0)) begin
          cur = command_queue.pop_front();
          in_cmd <= cur.cmd;
          in_value <= cur.value;
          nxt_valid = 1'b1;
        end
      end
    end
    in_valid <= nxt_valid;
  end

  always @(posedge clk_i) begin : observe
    logic    nxt_ready;
    result_t want;
    nxt_ready = out_ready;
    if (rst_ni) begin
      if (m_axis_tvalid_o && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d entry_value %0d last %0b",
                 m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
            mismatches++;
          end
          if (m_axis_tdata_o !== want.value) begin
            $error("entry_value: expected %0d, got %0d", want.value, m_axis_tdata_o);
            mismatches++;
          end
          if (m_axis_tlast_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast_o);
            mismatches++;
          end
        end
        if ($urandom_range(0, 63) == 0) idle_rx = !idle_rx;
      end
      // One long hold while the list is near full, so the input backs up
      if (!stall_done && stall_at != 0 && accepted_cnt >= stall_at) begin
        stall_done = 1'b1;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        if (idle_rx && command_queue.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
          rx_hold = $urandom_range(1, 18) - 1;
          nxt_ready = 1'b0;
        end
      end
    end
    out_ready <= nxt_ready;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && s_axis_tready_o) || (m_axis_tvalid_o && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  initial begin : run
    int   len;
    int   kind;
    int   r;
    cmd_e cmd;

    // Empty list, extremes, duplicates, head/middle/tail removal
    queue_command(CMD_LIST,   32'sd77, 1'b0);
    queue_command(CMD_SEARCH, '0, 1'b0);
    queue_command(CMD_REMOVE, '0, 1'b0);
    queue_command(CMD_INSERT, 32'sh8000_0000, 1'b0);
    queue_command(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
    queue_command(CMD_INSERT, '0, 1'b0);
    queue_command(CMD_INSERT, -32'sd1, 1'b0);
    queue_command(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
    queue_command(CMD_SEARCH, 32'sh7fff_ffff, 1'b0);
    queue_command(CMD_SEARCH, 32'sd5, 1'b0);
    queue_command(CMD_SEARCH, 32'sh8000_0000, 1'b0);
    queue_command(CMD_LIST,   -32'sd1, 1'b0);
    queue_command(CMD_REMOVE, 32'sh7fff_ffff, 1'b0);
    queue_command(CMD_LIST,   '0, 1'b0);
    queue_command(CMD_REMOVE, -32'sd1, 1'b0);
    queue_command(CMD_REMOVE, 32'sh8000_0000, 1'b0);
    queue_command(CMD_REMOVE, 32'sd12, 1'b0);
    queue_command(CMD_REMOVE, 32'sh7fff_ffff, 1'b0);
    queue_command(CMD_LIST,   32'sh5555_aaaa, 1'b0);
    queue_command(CMD_REMOVE, '0, 1'b0);
    queue_command(CMD_LIST,   32'shaaaa_5555, 1'b0);

    // Fill past capacity from an empty list, then list and trim
    for (int i = 0; i < CAPACITY + 3; i++)
      queue_command(CMD_INSERT, pick_value(), i == 0);
    stall_at = command_queue.size() - 6;
    queue_command(CMD_LIST, pick_value(), 1'b0);
    for (int i = 0; i < 6; i++)
      queue_command(i[0] ? CMD_SEARCH : CMD_REMOVE, pick_value(), 1'b0);

    // Random phases: growing, shrinking and balanced command mixes
    while (command_queue.size() < RANDOM_ITEMS) begin
      len = $urandom_range(15, 40);
      kind = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        case (kind)
          0:       cmd = (r < 55) ? CMD_INSERT : (r < 70) ? CMD_REMOVE :
                         (r < 90) ? CMD_SEARCH : CMD_LIST;
          1:       cmd = (r < 15) ? CMD_INSERT : (r < 70) ? CMD_REMOVE :
                         (r < 90) ? CMD_SEARCH : CMD_LIST;
          default: cmd = (r < 35) ? CMD_INSERT : (r < 60) ? CMD_REMOVE :
                         (r < 88) ? CMD_SEARCH : CMD_LIST;
        endcase
        queue_command(cmd, pick_value(), i == 0 && $urandom_range(0, 2) == 0);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (command_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
